FILE: src/cfp_pkg.sv
// Shared constants and types of the checksummed frame parser.
package cfp_pkg;

    // Default for the longest frame, in bytes, before the parser gives up.
    localparam int MAX_FRAME_LEN_DEF = 15;

    localparam logic [7:0] SYNC0 = 8'hAA;
    localparam logic [7:0] SYNC1 = 8'h55;

    // Header bytes beyond the payload length, and the header size that must be
    // passed before the second sync byte and the length are checked.
    localparam int LEN_EXTRA = 5;
    localparam int HDR_LEN   = 4;

    // Byte positions inside a frame.
    localparam int POS_SYNC1 = 1;
    localparam int POS_LEN   = 3;
    localparam int POS_CMD   = 4;

    // Command codes in byte four.
    localparam logic [7:0] CMD_TARGET  = 8'd1;
    localparam logic [7:0] CMD_PRESENT = 8'd2;

    // The frame buffer is held as rows of four bytes. Bytes 8 to 11 carry
    // the coordinates and form one row.
    localparam int ROW_BYTES = 4;
    localparam int ROW_BITS  = 8 * ROW_BYTES;
    localparam int COORD_ROW = 2;

    // One byte on its way from the header logic to the buffer row update.
    typedef struct packed {
        logic       valid;
        logic       done;        // this byte completed a frame
        logic       ok;          // ok flag after this byte
        logic       ld_target;   // good frame with the target command
        logic       ld_present;  // good frame with the present command
        logic       hit;         // the byte lies in the row that was read
        logic [1:0] lane;
        logic [7:0] data;
    } t_item;

    // One result as delivered on the output stream.
    typedef struct packed {
        logic        frame_ok;
        logic        frame_done;
        logic [15:0] target_x;
        logic [15:0] target_y;
        logic [15:0] present_x;
        logic [15:0] present_y;
    } t_result;

endpackage

FILE: src/checksummed_frame_parser.sv
// Top level of the checksummed frame parser: byte stream in, frame status out.
//
//  Channel   Direction  Handshake                     Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata[7:0] = received byte
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata = coordinates,
//                                                     tlast = frame done,
//                                                     tuser = frame ok
//
// One byte is taken per cycle while the result queue has room; each byte
// makes exactly one result, which passes the item register and the result
// queue before it is offered. The rate is set by the frame buffer RAM,
// which does one read-modify-write of a four-byte row per byte, with the
// previous cycle's write forwarded into the merge.
// Reset clears the byte count, the running sum, the ok flag, the coordinates
// and the pipeline; the frame buffer holds whatever it held and needs no
// clearing pass. When the consumer stalls, a two-entry result queue absorbs
// the bytes in flight and s_axis_tready drops once it would overflow.
module checksummed_frame_parser
    import cfp_pkg::*;
#(
    parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [15:0] target_x, [31:16] target_y,
                                        // [47:32] present_x, [63:48] present_y
    output logic        m_axis_tlast,   // frame_done
    output logic        m_axis_tuser    // frame_ok
);

    // The buffer holds MAX_FRAME_LEN + 1 bytes, as rows of four.
    localparam int CNT_W = $clog2(MAX_FRAME_LEN + 1);
    localparam int ROW_W = CNT_W - 2;
    localparam int NROW  = (MAX_FRAME_LEN + 1 + ROW_BYTES - 1) / ROW_BYTES;

    logic                accept;
    logic [ROW_W-1:0]    rd_row, wr_row, waddr;
    t_item               item;
    logic [ROW_BITS-1:0] rdata, wdata;
    logic                we, push;
    t_result             res, out_res;

    assign accept = s_axis_tvalid && s_axis_tready;

    cfp_ctrl #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN),
        .CNT_W         (CNT_W),
        .ROW_W         (ROW_W)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .o_rd_row (rd_row),
        .o_wr_row (wr_row),
        .o_item   (item)
    );

    cfp_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (NROW)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (rd_row),
        .o_rdata (rdata)
    );

    cfp_rmw #(
        .ROW_W (ROW_W)
    ) u_rmw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item),
        .i_row   (wr_row),
        .i_rdata (rdata),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata),
        .o_push  (push),
        .o_res   (res)
    );

    // The byte in the merge stage is counted as in flight.
    cfp_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_res    (res),
        .i_busy   (item.valid),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_res    (out_res),
        .o_room   (s_axis_tready)
    );

    assign m_axis_tdata = {out_res.present_y, out_res.present_x,
                           out_res.target_y, out_res.target_x};
    assign m_axis_tlast = out_res.frame_done;
    assign m_axis_tuser = out_res.frame_ok;

endmodule

FILE: src/cfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cfp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/cfp_ctrl.sv
// Header checks, byte count, running sum and ok flag of the frame parser.
module cfp_ctrl
    import cfp_pkg::*;
#(
    parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF,
    parameter int CNT_W         = $clog2(MAX_FRAME_LEN + 1),
    parameter int ROW_W         = CNT_W - 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    output logic [ROW_W-1:0] o_rd_row,
    output logic [ROW_W-1:0] o_wr_row,
    output t_item            o_item
);

    localparam int CMPW = (CNT_W + 1 > 9) ? CNT_W + 1 : 9;

    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_sum, n_sum;
    logic             r_ok, n_ok;
    logic             r_sync1_ok;
    logic [7:0]       r_len;
    logic             r_cmd_t, r_cmd_p;
    t_item            r_item, n_item;
    logic [ROW_W-1:0] r_wr_row, n_row;

    logic [CMPW-1:0]  c_ext, need;
    logic [ROW_W-1:0] k_row;
    logic             overlong, bad0, past_hdr, done;
    logic             cmd_t_now, cmd_p_now;

    always_comb begin
        c_ext     = CMPW'(r_count) + CMPW'(1);
        need      = CMPW'(r_len) + CMPW'(LEN_EXTRA);
        k_row     = r_count[CNT_W-1:2];
        overlong  = c_ext > CMPW'(MAX_FRAME_LEN);
        bad0      = (r_count == '0) && (i_byte != SYNC0);
        past_hdr  = c_ext > CMPW'(HDR_LEN);
        cmd_t_now = (r_count == CNT_W'(POS_CMD)) ? (i_byte == CMD_TARGET)  : r_cmd_t;
        cmd_p_now = (r_count == CNT_W'(POS_CMD)) ? (i_byte == CMD_PRESENT) : r_cmd_p;

        n_count = CNT_W'(c_ext);
        n_sum   = r_sum + i_byte;
        n_ok    = r_ok;
        done    = 1'b0;

        priority if (overlong || bad0) begin
            n_count = '0;
            n_sum   = '0;
            n_ok    = 1'b0;
        end else if (past_hdr && !r_sync1_ok) begin
            n_count = '0;
            n_sum   = '0;
            n_ok    = 1'b0;
        end else if (past_hdr && (c_ext >= need)) begin
            done    = 1'b1;
            n_ok    = (i_byte == r_sum);
            n_count = '0;
            n_sum   = '0;
        end else begin
            n_count = CNT_W'(c_ext);
        end

        // A completing frame fetches the coordinate row; any other byte
        // fetches the row it lands in.
        n_row = done ? ROW_W'(COORD_ROW) : k_row;

        n_item.valid      = i_accept;
        n_item.done       = done;
        n_item.ok         = n_ok;
        n_item.ld_target  = done && n_ok && cmd_t_now;
        n_item.ld_present = done && n_ok && cmd_p_now;
        n_item.hit        = (n_row == k_row);
        n_item.lane       = r_count[1:0];
        n_item.data       = i_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_ok    <= 1'b0;
        end else begin
            if (i_accept) begin
                r_count <= n_count;
                r_sum   <= n_sum;
                r_ok    <= n_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else begin
            r_item.valid <= n_item.valid;
        end
        if (i_accept) begin
            r_item.done       <= n_item.done;
            r_item.ok         <= n_item.ok;
            r_item.ld_target  <= n_item.ld_target;
            r_item.ld_present <= n_item.ld_present;
            r_item.hit        <= n_item.hit;
            r_item.lane       <= n_item.lane;
            r_item.data       <= n_item.data;
            r_wr_row          <= n_row;
            if (r_count == CNT_W'(POS_SYNC1)) begin
                r_sync1_ok <= (i_byte == SYNC1);
            end
            if (r_count == CNT_W'(POS_LEN)) begin
                r_len <= i_byte;
            end
            if (r_count == CNT_W'(POS_CMD)) begin
                r_cmd_t <= cmd_t_now;
                r_cmd_p <= cmd_p_now;
            end
        end
    end

    assign o_rd_row = n_row;
    assign o_wr_row = r_wr_row;
    assign o_item   = r_item;

endmodule

FILE: src/cfp_rmw.sv
// Row merge and write-back of the frame buffer, and the coordinate registers.
module cfp_rmw
    import cfp_pkg::*;
#(
    parameter int ROW_W = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_item               i_item,
    input  logic [ROW_W-1:0]    i_row,
    input  logic [ROW_BITS-1:0] i_rdata,
    output logic                o_we,
    output logic [ROW_W-1:0]    o_waddr,
    output logic [ROW_BITS-1:0] o_wdata,
    output logic                o_push,
    output t_result             o_res
);

    logic                r_fwd_valid;
    logic [ROW_W-1:0]    r_fwd_row;
    logic [ROW_BITS-1:0] r_fwd_data;
    logic [15:0]         r_tx, r_ty, r_px, r_py;
    logic [15:0]         n_tx, n_ty, n_px, n_py;
    logic [ROW_BITS-1:0] base, merged;

    always_comb begin
        // The read was issued in the same cycle as the previous write, so a
        // write to the same row from last cycle is not yet in the read data.
        base = (r_fwd_valid && (r_fwd_row == i_row)) ? r_fwd_data : i_rdata;
        merged = base;
        for (int l = 0; l < ROW_BYTES; l++) begin
            if (i_item.hit && (i_item.lane == 2'(l))) begin
                merged[8*l +: 8] = i_item.data;
            end
        end

        n_tx = r_tx;
        n_ty = r_ty;
        n_px = r_px;
        n_py = r_py;
        if (i_item.valid && i_item.ld_target) begin
            n_tx = {merged[7:0], merged[15:8]};
            n_ty = {merged[23:16], merged[31:24]};
        end
        if (i_item.valid && i_item.ld_present) begin
            n_px = {merged[7:0], merged[15:8]};
            n_py = {merged[23:16], merged[31:24]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
            r_tx        <= '0;
            r_ty        <= '0;
            r_px        <= '0;
            r_py        <= '0;
        end else begin
            r_fwd_valid <= o_we;
            r_tx        <= n_tx;
            r_ty        <= n_ty;
            r_px        <= n_px;
            r_py        <= n_py;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_row  <= i_row;
        r_fwd_data <= merged;
    end

    assign o_we    = i_item.valid && i_item.hit;
    assign o_waddr = i_row;
    assign o_wdata = merged;

    assign o_push           = i_item.valid;
    assign o_res.frame_ok   = i_item.ok;
    assign o_res.frame_done = i_item.done;
    assign o_res.target_x   = n_tx;
    assign o_res.target_y   = n_ty;
    assign o_res.present_x  = n_px;
    assign o_res.present_y  = n_py;

endmodule

FILE: src/cfp_outq.sv
// Two-entry result queue in front of the output stream.
module cfp_outq
    import cfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    input  logic    i_busy,
    input  logic    i_tready,
    output logic    o_tvalid,
    output t_result o_res,
    output logic    o_room
);

    t_result    r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_occ;
    logic [1:0] occ_left;
    logic       pop;

    always_comb begin
        pop      = (r_occ != 2'd0) && i_tready;
        occ_left = r_occ - 2'(pop);
        // A byte taken now reaches the queue after the item register; there must be
        // a place for it beside whatever is still in flight.
        o_room   = (occ_left == 2'd0) || ((occ_left == 2'd1) && !i_busy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_occ <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_occ <= r_occ + 2'(i_push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_res;
        end
    end

    assign o_tvalid = (r_occ != 2'd0);
    assign o_res    = r_q[r_rp];

endmodule
